### design/slrs_pkg.sv
// ----------------------------------------------------------------------------
// slrs_pkg
// shared constants for the sorted line record store: field widths, command
// codes and default sizes
// ----------------------------------------------------------------------------
package slrs_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 16;
  localparam int LEN_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int OFF_W    = 12;
  localparam int CAP_W    = 13;
  localparam int SIZE_W   = 9;   // header plus longest body

  localparam int STORE_BYTES_DEF = 4096;
  localparam int MAX_BODY_DEF    = 255;
  localparam int HDR_BYTES       = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;
  localparam logic [LEN_W-1:0] CNT_SAT   = 8'hFF;

  localparam logic [CMD_W-1:0] CMD_FIND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

endpackage

### design/slrs_cmd_if.sv
// ----------------------------------------------------------------------------
// slrs_cmd_if
// command channel: find, set body byte, read store byte
// ----------------------------------------------------------------------------
interface slrs_cmd_if import slrs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [KEY_W-1:0] line_number;
  logic [LEN_W-1:0]        line_length;
  logic [BYTE_W-1:0]       data_byte;
  logic [OFF_W-1:0]        read_offset;
  logic                    last;

  modport source (output valid, command, line_number, line_length, data_byte,
                  read_offset, last, input ready);
  modport sink (input valid, command, line_number, line_length, data_byte,
                read_offset, last, output ready);
endinterface

### design/slrs_res_if.sv
// ----------------------------------------------------------------------------
// slrs_res_if
// result channel: status, record offset, read byte, bytes in use
// ----------------------------------------------------------------------------
interface slrs_res_if import slrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               success;
  logic [OFF_W-1:0]   record_offset;
  logic [BYTE_W-1:0]  read_data;
  logic [CAP_W-1:0]   used_bytes;

  modport source (output valid, success, record_offset, read_data, used_bytes,
                  input ready);
  modport sink (input valid, success, record_offset, read_data, used_bytes,
                output ready);
endinterface

### design/slrs_cfg_if.sv
// ----------------------------------------------------------------------------
// slrs_cfg_if
// capacity register write channel
// ----------------------------------------------------------------------------
interface slrs_cfg_if import slrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### design/slrs_ram.sv
// ----------------------------------------------------------------------------
// slrs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module slrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sorted_line_record_store.sv
// steps: a read does one registered store read; a find walks the record
//   headers; a set byte that is not last is only staged; a last set byte
//   walks the records, moves any tail bytes, writes any header and body bytes;
//   all commands but a staged byte then present a result beat
// throughput: one command at a time, bounded by the single store read port
// reset: control, used count and staging count cleared, capacity set to 4096
//   at once; store and staging contents are left as they are, no clearing pass
// ----------------------------------------------------------------------------
// sorted_line_record_store
// keyed variable-length records kept in ascending key order in a byte store,
// with find, insert/replace/delete by tail move, and a byte read port
// ----------------------------------------------------------------------------
module sorted_line_record_store import slrs_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  parameter int MAX_BODY    = MAX_BODY_DEF
) (
  input logic         clk,
  input logic         rst,
  slrs_cmd_if.sink    cmd,
  slrs_res_if.source  res,
  slrs_cfg_if.sink    cfg
);

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int UW  = $clog2(STORE_BYTES + 1);
  localparam int SAW = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
  localparam int CW  = ((UW > CAP_W) ? UW : CAP_W) + 2;
  localparam int XW  = UW + SIZE_W + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_WALK_A  = 4'd1;
  localparam logic [3:0] S_WALK_B  = 4'd2;
  localparam logic [3:0] S_WALK_C  = 4'd3;
  localparam logic [3:0] S_WALK_D  = 4'd4;
  localparam logic [3:0] S_WALK_E  = 4'd5;
  localparam logic [3:0] S_FIT     = 4'd6;
  localparam logic [3:0] S_MOVE_RD = 4'd7;
  localparam logic [3:0] S_MOVE_WR = 4'd8;
  localparam logic [3:0] S_HDR0    = 4'd9;
  localparam logic [3:0] S_HDR1    = 4'd10;
  localparam logic [3:0] S_HDR2    = 4'd11;
  localparam logic [3:0] S_BODY_RD = 4'd12;
  localparam logic [3:0] S_BODY_WR = 4'd13;
  localparam logic [3:0] S_READ    = 4'd14;
  localparam logic [3:0] S_EMIT    = 4'd15;

  logic [3:0]              state;
  logic [CAP_W-1:0]        capacity;
  logic [UW-1:0]           used;
  logic [LEN_W-1:0]        stage_cnt;
  logic                    is_set;
  logic signed [KEY_W-1:0] key;
  logic [LEN_W-1:0]        len;
  logic [UW-1:0]           off;
  logic [BYTE_W-1:0]       lo;
  logic [BYTE_W-1:0]       hi;
  logic [SIZE_W-1:0]       oldsz;
  logic [UW-1:0]           src;
  logic [UW-1:0]           remain;
  logic                    dir_up;
  logic [SIZE_W-1:0]       delta;
  logic [LEN_W-1:0]        idx;
  logic                    in_range;
  logic                    res_ok;
  logic [UW-1:0]           res_off;
  logic [BYTE_W-1:0]       res_data;

  logic                    out_valid;
  logic                    out_ok;
  logic [UW-1:0]           out_off;
  logic [BYTE_W-1:0]       out_data;
  logic [UW-1:0]           out_used;

  // store ram ports
  logic                    st_we;
  logic [AW-1:0]           st_waddr;
  logic [BYTE_W-1:0]       st_wdata;
  logic [AW-1:0]           st_raddr;
  logic [BYTE_W-1:0]       st_rdata;
  // staging ram ports
  logic                    sg_we;
  logic [SAW-1:0]          sg_raddr;
  logic [BYTE_W-1:0]       sg_rdata;

  logic                    accept;
  logic [LEN_W-1:0]        cnt_inc;
  logic                    pre_fail;
  logic signed [KEY_W-1:0] kval;
  logic [UW-1:0]           off_step;
  logic [SIZE_W-1:0]       need;
  logic [CW-1:0]           total;
  logic [CW-1:0]           cap_x;
  logic [CW-1:0]           cap_eff;
  logic [UW-1:0]           tail;

  slrs_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  slrs_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_BODY)) u_stage (
    .clk   (clk),
    .we    (sg_we),
    .waddr (stage_cnt[SAW-1:0]),
    .wdata (cmd.data_byte),
    .raddr (sg_raddr),
    .rdata (sg_rdata)
  );

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = cmd.valid && cmd.ready;

  assign res.valid         = out_valid;
  assign res.success       = out_ok;
  assign res.record_offset = OFF_W'(out_off);
  assign res.read_data     = out_data;
  assign res.used_bytes    = CAP_W'(out_used);

  assign cnt_inc  = (stage_cnt != CNT_SAT) ? stage_cnt + 8'd1 : stage_cnt;
  assign pre_fail = (cmd.line_length > LEN_W'(MAX_BODY)) ||
                    ((cmd.line_length != '0) && (cnt_inc != cmd.line_length));
  assign sg_we    = accept && (cmd.command == CMD_SET) && (cmd.line_length != '0) &&
                    (stage_cnt < LEN_W'(MAX_BODY));
  assign sg_raddr = idx[SAW-1:0];

  assign kval     = {hi, lo};
  assign off_step = UW'(XW'(off) + XW'(HDR_BYTES) + XW'(st_rdata));
  assign need     = (len != '0) ? SIZE_W'(HDR_BYTES) + SIZE_W'(len) : '0;
  assign total    = CW'(used) - CW'(oldsz) + CW'(need);
  assign cap_x    = CW'(capacity);
  assign cap_eff  = (cap_x > CW'(STORE_BYTES)) ? CW'(STORE_BYTES) : cap_x;
  assign tail     = UW'(CW'(used) - CW'(off) - CW'(oldsz));

  always_comb begin
    st_we    = 1'b0;
    st_waddr = AW'(off);
    st_wdata = st_rdata;
    st_raddr = AW'(off);
    unique case (state)
      S_IDLE:    st_raddr = AW'(cmd.read_offset);
      S_WALK_B:  st_raddr = AW'(XW'(off) + XW'(1));
      S_WALK_C:  st_raddr = AW'(XW'(off) + XW'(2));
      S_WALK_D:  st_raddr = AW'(XW'(off) + XW'(2));
      S_MOVE_RD: st_raddr = AW'(src);
      S_MOVE_WR: begin
        st_we    = 1'b1;
        st_waddr = dir_up ? AW'(CW'(src) + CW'(delta)) : AW'(CW'(src) - CW'(delta));
      end
      S_HDR0: begin
        st_we    = 1'b1;
        st_wdata = key[7:0];
      end
      S_HDR1: begin
        st_we    = 1'b1;
        st_waddr = AW'(XW'(off) + XW'(1));
        st_wdata = key[15:8];
      end
      S_HDR2: begin
        st_we    = 1'b1;
        st_waddr = AW'(XW'(off) + XW'(2));
        st_wdata = len;
      end
      S_BODY_WR: begin
        st_we    = 1'b1;
        st_waddr = AW'(XW'(off) + XW'(HDR_BYTES) + XW'(idx));
        st_wdata = sg_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= CAP_RESET;
      used      <= '0;
      stage_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.data;
      end
      if (out_valid && res.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key <= cmd.line_number;
            len <= cmd.line_length;
            off <= '0;
            case (cmd.command)
              CMD_FIND: begin
                is_set <= 1'b0;
                state  <= S_WALK_A;
              end
              CMD_SET: begin
                if (cmd.last) begin
                  stage_cnt <= '0;
                  is_set    <= 1'b1;
                  if (pre_fail) begin
                    res_ok   <= 1'b0;
                    res_off  <= '0;
                    res_data <= '0;
                    state    <= S_EMIT;
                  end else begin
                    state <= S_WALK_A;
                  end
                end else if (cmd.line_length != '0) begin
                  stage_cnt <= cnt_inc;
                end
              end
              CMD_READ: begin
                in_range <= (CW'(cmd.read_offset) < CW'(STORE_BYTES));
                state    <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          res_ok   <= 1'b0;
          res_off  <= '0;
          res_data <= in_range ? st_rdata : '0;
          state    <= S_EMIT;
        end
        S_WALK_A: begin
          if (off < used) begin
            state <= S_WALK_B;
          end else if (is_set) begin
            oldsz <= '0;
            state <= S_FIT;
          end else begin
            res_ok   <= 1'b0;
            res_off  <= '0;
            res_data <= '0;
            state    <= S_EMIT;
          end
        end
        S_WALK_B: begin
          lo    <= st_rdata;
          state <= S_WALK_C;
        end
        S_WALK_C: begin
          hi    <= st_rdata;
          state <= S_WALK_D;
        end
        S_WALK_D: state <= S_WALK_E;
        S_WALK_E: begin
          // st_rdata holds the body length of the record at off
          if (kval == key) begin
            if (is_set) begin
              oldsz <= SIZE_W'(HDR_BYTES) + SIZE_W'(st_rdata);
              state <= S_FIT;
            end else begin
              res_ok   <= 1'b1;
              res_off  <= off;
              res_data <= '0;
              state    <= S_EMIT;
            end
          end else if (is_set && (kval > key)) begin
            oldsz <= '0;
            state <= S_FIT;
          end else begin
            off   <= off_step;
            state <= S_WALK_A;
          end
        end
        S_FIT: begin
          res_data <= '0;
          if (total > cap_eff) begin
            res_ok  <= 1'b0;
            res_off <= '0;
            state   <= S_EMIT;
          end else begin
            used   <= UW'(total);
            remain <= tail;
            if (need > oldsz) begin
              // grow: move the tail up, highest byte first
              dir_up <= 1'b1;
              delta  <= need - oldsz;
              src    <= used - UW'(1);
            end else begin
              dir_up <= 1'b0;
              delta  <= oldsz - need;
              src    <= UW'(CW'(off) + CW'(oldsz));
            end
            if ((need != oldsz) && (tail != '0)) begin
              state <= S_MOVE_RD;
            end else if (need != '0) begin
              state <= S_HDR0;
            end else begin
              res_ok  <= 1'b1;
              res_off <= '0;
              state   <= S_EMIT;
            end
          end
        end
        S_MOVE_RD: state <= S_MOVE_WR;
        S_MOVE_WR: begin
          remain <= remain - UW'(1);
          src    <= dir_up ? src - UW'(1) : src + UW'(1);
          if (remain != UW'(1)) begin
            state <= S_MOVE_RD;
          end else if (need != '0) begin
            state <= S_HDR0;
          end else begin
            res_ok  <= 1'b1;
            res_off <= '0;
            state   <= S_EMIT;
          end
        end
        S_HDR0: state <= S_HDR1;
        S_HDR1: state <= S_HDR2;
        S_HDR2: begin
          idx   <= '0;
          state <= S_BODY_RD;
        end
        S_BODY_RD: state <= S_BODY_WR;
        S_BODY_WR: begin
          idx <= idx + 8'd1;
          if (idx == len - 8'd1) begin
            res_ok  <= 1'b1;
            res_off <= off;
            state   <= S_EMIT;
          end else begin
            state <= S_BODY_RD;
          end
        end
        S_EMIT: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_ok    <= res_ok;
            out_off   <= res_off;
            out_data  <= res_data;
            out_used  <= used;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(STORE_BYTES))
    else $error("bytes in use beyond store size");

  a_stage_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.command == CMD_SET) && cmd.last) |=> (stage_cnt == '0))
    else $error("staging count not cleared after last set beat");

  a_used_only_fit: assert property (@(posedge clk) disable iff (rst)
    (!rst && (state != S_FIT)) |=> $stable(used))
    else $error("used count changed outside fit step");

  a_move_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE_RD) |-> (remain != '0))
    else $error("tail move with nothing left");

endmodule
